// ----- rtl/debounce_encoder_event_unit_defines.svh -----
// Assertion macros for the debounce and encoder event unit.
// No dependencies; included by files that carry concurrent checks.
`ifndef DEBOUNCE_ENCODER_EVENT_UNIT_DEFINES_SVH
`define DEBOUNCE_ENCODER_EVENT_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while in reset.
`define DEU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Clocked check that also holds during reset.
`define DEU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DEU_ASSERT(lbl, prop, msg)
`define DEU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/deu_pkg.sv -----
// Shared types and constants for the debounce and encoder event unit.
// No dependencies.
package deu_pkg;

  localparam int NUM_CH = 7;
  localparam int CODE_W = 3;
  localparam int POS_W  = 16;

  typedef logic [CODE_W-1:0] code_t;

  localparam code_t CH_BUTTON = 3'd0;
  localparam code_t CH_ENC_A  = 3'd1;
  localparam code_t CH_ENC_B  = 3'd2;
  localparam code_t CH_STOP   = 3'd3;
  localparam code_t CH_XMIN   = 3'd4;
  localparam code_t CH_XMAX   = 3'd5;
  localparam code_t CH_YMIN   = 3'd6;

  typedef enum logic [1:0] {
    DIR_NONE = 2'b00,
    DIR_UP   = 2'b01,
    DIR_DOWN = 2'b11
  } dir_e;

  typedef struct packed {
    logic settle_hi;
    logic settle_lo;
  } lane_status_t;

endpackage

// ----- rtl/deu_lane.sv -----
// One debounce lane: signed run counter for a single pin level.
// Depends on deu_pkg.
module deu_lane #(
  parameter int STABLE_SAMPLES = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  level_i,
  output deu_pkg::lane_status_t status_o
);

  localparam int CntW = $clog2(STABLE_SAMPLES + 1) + 1;
  localparam logic signed [CntW-1:0] Zero    = '0;
  localparam logic signed [CntW-1:0] One     = CntW'(1);
  localparam logic signed [CntW-1:0] NegOne  = -One;
  localparam logic signed [CntW-1:0] Lim     = CntW'(STABLE_SAMPLES);
  localparam logic signed [CntW-1:0] LimM1   = CntW'(STABLE_SAMPLES - 1);
  localparam logic signed [CntW-1:0] NegLim  = -Lim;
  localparam logic signed [CntW-1:0] NegLimM1 = -LimM1;

  logic signed [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    status_o = '0;
    if (level_i) begin
      if (cnt_q <= Zero) begin
        cnt_d = One;
      end else if (cnt_q < Lim) begin
        cnt_d = cnt_q + One;
        status_o.settle_hi = (cnt_q == LimM1);
      end
    end else begin
      if (cnt_q >= Zero) begin
        cnt_d = NegOne;
      end else if (cnt_q > NegLim) begin
        cnt_d = cnt_q - One;
        status_o.settle_lo = (cnt_q == NegLimM1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= Zero;
    end else if (en_i) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/deu_merge.sv -----
// Merge stage: encoder position and direction, event mask and serialiser.
// Depends on deu_pkg and debounce_encoder_event_unit_defines.svh.
`include "debounce_encoder_event_unit_defines.svh"

module deu_merge (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        tick_i,
  input  logic                                        preset_i,
  input  logic signed [deu_pkg::POS_W-1:0]            preset_value_i,
  input  deu_pkg::lane_status_t [deu_pkg::NUM_CH-1:0] lane_i,
  output logic                                        ready_o,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output deu_pkg::code_t                              event_code_o,
  output logic                                        active_flag_o,
  output logic signed [deu_pkg::POS_W-1:0]            position_o,
  output logic                                        motor_x_disable_o,
  output logic                                        last_o
);

  localparam int N = deu_pkg::NUM_CH;

  logic [N-1:0] mask_q, mask_d, mask_new, mask_rest;
  logic [N-1:0] act_q, act_new;
  logic signed [deu_pkg::POS_W-1:0] pos_q, pos_step, pos_old_q, pos_new_q;
  deu_pkg::dir_e dir_q, dir_d;
  logic out_xfer;

  function automatic deu_pkg::code_t lowest(input logic [N-1:0] m);
    deu_pkg::code_t c;
    c = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (m[i]) c = deu_pkg::CODE_W'(i);
    end
    return c;
  endfunction

  always_comb begin
    for (int i = 0; i < N; i++) begin
      mask_new[i] = lane_i[i].settle_hi | lane_i[i].settle_lo;
      act_new[i]  = lane_i[i].settle_lo;
    end
    // enc A fires on settled low only; enc B never fires
    mask_new[deu_pkg::CH_ENC_A] = lane_i[deu_pkg::CH_ENC_A].settle_lo;
    act_new[deu_pkg::CH_ENC_A]  = 1'b0;
    mask_new[deu_pkg::CH_ENC_B] = 1'b0;
    act_new[deu_pkg::CH_ENC_B]  = 1'b0;
  end

  always_comb begin
    pos_step = pos_q;
    if (lane_i[deu_pkg::CH_ENC_A].settle_lo) begin
      unique case (dir_q)
        deu_pkg::DIR_UP:   pos_step = pos_q + 16'sd1;
        deu_pkg::DIR_DOWN: pos_step = pos_q - 16'sd1;
        default:           pos_step = pos_q;
      endcase
    end
    dir_d = dir_q;
    if (lane_i[deu_pkg::CH_ENC_B].settle_hi) begin
      dir_d = deu_pkg::DIR_UP;
    end else if (lane_i[deu_pkg::CH_ENC_B].settle_lo) begin
      dir_d = deu_pkg::DIR_DOWN;
    end
  end

  assign mask_rest   = mask_q & (mask_q - N'(1));
  assign out_valid_o = |mask_q;
  assign last_o      = out_valid_o && (mask_rest == '0);
  assign out_xfer    = out_valid_o && out_ready_i;
  assign ready_o     = !out_valid_o || (out_ready_i && last_o);

  assign event_code_o      = lowest(mask_q);
  assign active_flag_o     = act_q[event_code_o];
  assign position_o        = (event_code_o == deu_pkg::CH_BUTTON) ? pos_old_q : pos_new_q;
  assign motor_x_disable_o = (event_code_o == deu_pkg::CH_STOP) && !active_flag_o;

  always_comb begin
    mask_d = mask_q;
    if (tick_i) begin
      mask_d = mask_new;
    end else if (out_xfer) begin
      mask_d = mask_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      pos_q  <= '0;
      dir_q  <= deu_pkg::DIR_NONE;
    end else begin
      mask_q <= mask_d;
      if (preset_i) begin
        pos_q <= preset_value_i;
      end else if (tick_i) begin
        pos_q <= pos_step;
        dir_q <= dir_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i) begin
      act_q     <= act_new;
      pos_old_q <= pos_q;
      pos_new_q <= pos_step;
    end
  end

  `DEU_ASSERT(a_no_enc_b_event, out_valid_o |-> event_code_o != deu_pkg::CH_ENC_B, "enc B event")
  `DEU_ASSERT(a_tick_no_loss, tick_i && out_valid_o |-> out_ready_i && last_o, "tick overwrote events")
  `DEU_ASSERT(a_burst_cont, out_xfer && !last_o |=> out_valid_o, "event burst broken")
  `DEU_ASSERT(a_mdis_stop, out_valid_o && motor_x_disable_o |-> event_code_o == deu_pkg::CH_STOP, "mdis off stop")

endmodule

// ----- rtl/debounce_encoder_event_unit.sv -----
// Top level of the debounce and encoder event unit: seven debounce lanes and merge stage.
// Depends on deu_pkg, deu_lane, deu_merge.
//
//  channel | signals                                   | direction
//  in      | in_valid_i/in_ready_o, req_type_i,        | input
//          | raw_levels_i, position_value_i            |
//  out     | out_valid_o/out_ready_i, event_code_o,    | output
//          | active_flag_o, position_o, motor_x_disable_o, last_o |
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_invert_y_min_i | input
//
// All seven lanes update in the cycle a tick transfer is taken.
// Events then leave at one per cycle while out_ready_i is high, up to 6 per tick, through the
// single output serialiser; the next item is taken with the last event.
// A preset or an eventless tick raises no events, so the input stays ready. Reset clears counters, direction, position.
// Output stalls hold the pending events and back-pressure the input.
module debounce_encoder_event_unit #(
  parameter int STABLE_SAMPLES = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              req_type_i,
  input  logic [6:0]                        raw_levels_i,
  input  logic signed [deu_pkg::POS_W-1:0]  position_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [deu_pkg::CODE_W-1:0]        event_code_o,
  output logic                              active_flag_o,
  output logic signed [deu_pkg::POS_W-1:0]  position_o,
  output logic                              motor_x_disable_o,
  output logic                              last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_invert_y_min_i
);

  logic inv_q;
  logic in_xfer, tick, preset;
  logic [deu_pkg::NUM_CH-1:0] levels;
  deu_pkg::lane_status_t [deu_pkg::NUM_CH-1:0] lane_st;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      inv_q <= cfg_invert_y_min_i;
    end
  end

  assign in_xfer = in_valid_i && in_ready_o;
  assign tick    = in_xfer && !req_type_i;
  assign preset  = in_xfer && req_type_i;

  always_comb begin
    levels = raw_levels_i;
    levels[deu_pkg::CH_YMIN] = raw_levels_i[deu_pkg::CH_YMIN] ^ inv_q;
  end

  for (genvar g = 0; g < deu_pkg::NUM_CH; g++) begin : g_lane
    deu_lane #(
      .STABLE_SAMPLES(STABLE_SAMPLES)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (tick),
      .level_i (levels[g]),
      .status_o(lane_st[g])
    );
  end

  deu_merge u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_i           (tick),
    .preset_i         (preset),
    .preset_value_i   (position_value_i),
    .lane_i           (lane_st),
    .ready_o          (in_ready_o),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_code_o     (event_code_o),
    .active_flag_o    (active_flag_o),
    .position_o       (position_o),
    .motor_x_disable_o(motor_x_disable_o),
    .last_o           (last_o)
  );

endmodule
